/* sv/milenage_auth_functions_defines.svh */
// Assertion macros shared by the Milenage checker.
// No dependencies; included by files that assert.
`ifndef MILENAGE_AUTH_FUNCTIONS_DEFINES_SVH
`define MILENAGE_AUTH_FUNCTIONS_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MIL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Milenage check failed");
// Condition that holds on every clock edge outside reset.
`define MIL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("Milenage check failed");
`endif

/* sv/mil_pkg.sv */
// Package for the Milenage block: AES tables, round and key schedule functions.
// No dependencies.
package mil_pkg;

  localparam int unsigned Rounds = 10;
  localparam int unsigned AesLat = Rounds + 1;

  typedef enum logic [1:0] {
    REG_KEY_HI = 2'd0,
    REG_KEY_LO = 2'd1,
    REG_OPC_HI = 2'd2,
    REG_OPC_LO = 2'd3
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round without the round key; the last round skips MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      sb[i] = s[127 - 8 * i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4 * c] = SBOX[sb[j + 4 * ((c + j) % 4)]];
      end
    end
    r = '0;
    for (int c = 0; c < 4; c++) begin
      all = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
      for (int j = 0; j < 4; j++) begin
        if (last) begin
          r[127 - 8 * (4 * c + j) -: 8] = t[4 * c + j];
        end else begin
          r[127 - 8 * (4 * c + j) -: 8] = t[4 * c + j] ^ all ^
              xt(t[4 * c + j] ^ t[4 * c + ((j + 1) % 4)]);
        end
      end
    end
    aes_round = r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    g  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ g;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_next = {w0, w1, w2, w3};
  endfunction

endpackage

/* sv/mil_aes_pipe.sv */
// AES-128 encryption pipeline, one round and one key schedule step per stage.
// Depends on mil_pkg.
module mil_aes_pipe (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [127:0] key_i,
  input  logic [127:0] blk_i,
  output logic         valid_o,
  output logic [127:0] blk_o
);
  import mil_pkg::*;

  logic [127:0] st_q [AesLat];
  logic [127:0] rk_q [AesLat];
  logic [AesLat-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[AesLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= blk_i ^ key_i;
    rk_q[0] <= key_i;
  end

  for (genvar r = 1; r < AesLat; r++) begin : g_round
    logic [127:0] nk_d;
    assign nk_d = key_next(rk_q[r-1], RCON[r-1]);
    always_ff @(posedge clk_i) begin
      st_q[r] <= aes_round(st_q[r-1], r == AesLat - 1) ^ nk_d;
      rk_q[r] <= nk_d;
    end
  end

  assign valid_o = v_q[AesLat-1];
  assign blk_o   = st_q[AesLat-1];
endmodule

/* sv/milenage_auth_functions.sv */
// Top level of the Milenage f1..f5* block on AES-128 with an APB register port.
// Depends on mil_pkg and mil_aes_pipe.
//
// Usage: write K and OPc through the APB port (64-bit registers at byte
// addresses 0, 8, 16 and 24: key_hi, key_lo, opc_hi, opc_lo) while the block
// holds no beat in flight. A beat enters when start is high and busy is low.
// Busy never rises, so a new beat can enter in every clock cycle.
// The first AES pipeline forms TEMP. Five AES pipelines then compute OUT1
// to OUT5 side by side, and one output register follows. Each result
// appears on the result ports with done_o high for exactly one cycle.
// Throughput is one beat per cycle, set by the one-round-per-stage AES
// pipelines.
// Reset clears the key and OPc registers to zero and drops all beats in flight.
// The receiver cannot stall, so no result waits and none is held back.
module milenage_auth_functions (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] rand_hi_i,
  input  logic [63:0] rand_lo_i,
  input  logic [47:0] sqn_i,
  input  logic [15:0] amf_i,
  output logic        done_o,
  output logic [63:0] mac_a_o,
  output logic [63:0] mac_s_o,
  output logic [63:0] res_o,
  output logic [63:0] ck_hi_o,
  output logic [63:0] ck_lo_o,
  output logic [63:0] ik_hi_o,
  output logic [63:0] ik_lo_o,
  output logic [47:0] ak_o,
  output logic [47:0] ak_star_o
);
  import mil_pkg::*;

  logic [63:0] key_hi_q, key_lo_q, opc_hi_q, opc_lo_q;
  reg_idx_e    idx;
  logic [127:0] key, opc;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign idx    = reg_idx_e'(paddr[4:3]);
  assign key    = {key_hi_q, key_lo_q};
  assign opc    = {opc_hi_q, opc_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      opc_hi_q <= '0;
      opc_lo_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_KEY_HI: key_hi_q <= pwdata;
        REG_KEY_LO: key_lo_q <= pwdata;
        REG_OPC_HI: opc_hi_q <= pwdata;
        REG_OPC_LO: opc_lo_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_HI: prdata = key_hi_q;
      REG_KEY_LO: prdata = key_lo_q;
      REG_OPC_HI: prdata = opc_hi_q;
      REG_OPC_LO: prdata = opc_lo_q;
      default:    prdata = '0;
    endcase
  end

  logic         acc;
  logic         tv;
  logic [127:0] temp;
  logic [63:0]  side_q [AesLat];

  assign acc = start && !busy;

  mil_aes_pipe u_temp (
    .clk_i, .rst_ni,
    .valid_i (acc),
    .key_i   (key),
    .blk_i   ({rand_hi_i, rand_lo_i} ^ opc),
    .valid_o (tv),
    .blk_o   (temp)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= {sqn_i, amf_i};
    for (int i = 1; i < AesLat; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  logic [127:0] a;
  logic [127:0] b [5];
  logic [127:0] o [5];
  logic         ov;

  assign a    = temp ^ opc;
  assign b[0] = temp ^ {side_q[AesLat-1], side_q[AesLat-1]} ^ {opc_lo_q, opc_hi_q};
  assign b[1] = a ^ 128'h1;
  assign b[2] = {a[95:0], a[127:96]} ^ 128'h2;
  assign b[3] = {a[63:0], a[127:64]} ^ 128'h4;
  assign b[4] = {a[31:0], a[127:32]} ^ 128'h8;

  mil_aes_pipe u_out0 (
    .clk_i, .rst_ni, .valid_i (tv), .key_i (key), .blk_i (b[0]),
    .valid_o (ov), .blk_o (o[0])
  );

  for (genvar g = 1; g < 5; g++) begin : g_out
    mil_aes_pipe u_out (
      .clk_i, .rst_ni, .valid_i (tv), .key_i (key), .blk_i (b[g]),
      .valid_o (), .blk_o (o[g])
    );
  end

  logic [127:0] r1, r2, r3, r4, r5;
  assign r1 = o[0] ^ opc;
  assign r2 = o[1] ^ opc;
  assign r3 = o[2] ^ opc;
  assign r4 = o[3] ^ opc;
  assign r5 = o[4] ^ opc;

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ov;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_a_o   <= r1[127:64];
    mac_s_o   <= r1[63:0];
    res_o     <= r2[63:0];
    ak_o      <= r2[127:80];
    ck_hi_o   <= r3[127:64];
    ck_lo_o   <= r3[63:0];
    ik_hi_o   <= r4[127:64];
    ik_lo_o   <= r4[63:0];
    ak_star_o <= r5[127:80];
  end

  assign done_o = done_q;
endmodule

/* sv/mil_checker.sv */
// Port-level checks for the Milenage block, bound to the top level.
// Depends on milenage_auth_functions_defines.svh.
`include "milenage_auth_functions_defines.svh"
module mil_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic psel,
  input logic penable,
  input logic pready,
  input logic done_o
);
  `MIL_ASSERT_IMPL(a_done_latency, done_o, $past(start && !busy, 23))
  `MIL_ASSERT_ALWAYS(a_never_busy, !busy)
  `MIL_ASSERT_IMPL(a_apb_ready, psel && penable, pready)
endmodule

bind milenage_auth_functions mil_checker u_mil_checker (
  .clk_i, .rst_ni, .start, .busy, .psel, .penable, .pready, .done_o
);
